>>> rtl/core/rmsp_pkg.sv
// ----------------------------------------------------------------------------
// rmsp_pkg
// Shared constants, types and helpers for the regret matching step block.
// ----------------------------------------------------------------------------
package rmsp_pkg;

  localparam int REGRET_WIDTH   = 32;
  localparam int PROB_FRAC_BITS = 16;
  localparam int SUM_WIDTH      = 48;

  localparam int RND_W   = 16;
  localparam int ACT_W   = 2;
  localparam int PROB_W  = PROB_FRAC_BITS + 1;
  localparam int POS_W   = REGRET_WIDTH - 1;
  localparam int TOT_W   = POS_W + 2;
  localparam int CUM_W   = PROB_W + 2;
  localparam int CMP_W   = CUM_W + 16;
  localparam int DIV_CNT_W = $clog2(PROB_FRAC_BITS);

  localparam int OUT_PROB_W   = 17;
  localparam int OUT_SUM_W    = 48;
  localparam int IN_W         = 2 * RND_W;
  localparam int OUT_FIELDS_W = 2 * ACT_W + 6 * OUT_PROB_W + 3 * OUT_SUM_W;
  localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [PROB_W-1:0] PROB_ONE     = PROB_W'(1) << PROB_FRAC_BITS;
  localparam logic [PROB_W-1:0] PROB_UNIFORM = PROB_W'((64'd1 << PROB_FRAC_BITS) / 3);

  typedef logic [ACT_W-1:0] act_t;

  localparam act_t ACT_ROCK     = 2'd0;
  localparam act_t ACT_PAPER    = 2'd1;
  localparam act_t ACT_SCISSORS = 2'd2;

  localparam logic PLAYER_MY  = 1'b0;
  localparam logic PLAYER_OPP = 1'b1;

  typedef struct packed {
    logic capture;
    logic load_total;
    logic div_start;
    logic div_step;
    logic div_store;
    logic sample;
    logic commit;
    logic player;
    act_t act;
  } rmsp_cmd_t;

  typedef struct packed {
    logic bypass;
  } rmsp_stat_t;

  // +1 win, -1 loss, 0 tie for act against other
  function automatic logic signed [1:0] utility(input act_t act, input act_t other);
    act_t beats;
    act_t loses;
    beats = (other == ACT_SCISSORS) ? ACT_ROCK : act_t'(other + 2'd1);
    loses = (other == ACT_ROCK) ? ACT_SCISSORS : act_t'(other - 2'd1);
    if (act == beats) return 2'sd1;
    if (act == loses) return -2'sd1;
    return 2'sd0;
  endfunction

endpackage

>>> rtl/core/rmsp_ctrl.sv
// ----------------------------------------------------------------------------
// rmsp_ctrl
// Sequencer: strategy build, shared divider steps, sampling and commit.
// ----------------------------------------------------------------------------
module rmsp_ctrl
  import rmsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  output logic       out_tvalid,
  input  logic       out_tready,
  input  rmsp_stat_t stat,
  output rmsp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_TOTAL, S_SETUP, S_DIV, S_STORE, S_SAMPLE, S_FIN
  } state_t;

  state_t               state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  act_t                 act_r, act_nxt;
  logic                 player_r, player_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 slot_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign slot_free  = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    act_nxt       = act_r;
    player_nxt    = player_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    cmd.player    = player_r;
    cmd.act       = act_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          player_nxt  = PLAYER_MY;
          act_nxt     = ACT_ROCK;
          state_nxt   = S_TOTAL;
        end
      end
      S_TOTAL: begin
        cmd.load_total = 1'b1;
        state_nxt      = S_SETUP;
      end
      S_SETUP: begin
        cmd.div_start = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = stat.bypass ? S_STORE : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = DIV_CNT_W'(cnt_r + 1'b1);
        if (cnt_r == DIV_CNT_W'(PROB_FRAC_BITS - 1)) begin
          state_nxt = S_STORE;
        end
      end
      S_STORE: begin
        cmd.div_store = 1'b1;
        if (act_r == ACT_SCISSORS) begin
          act_nxt = ACT_ROCK;
          if (player_r == PLAYER_OPP) begin
            state_nxt = S_SAMPLE;
          end else begin
            player_nxt = PLAYER_OPP;
            state_nxt  = S_TOTAL;
          end
        end else begin
          act_nxt   = act_t'(act_r + 1'b1);
          state_nxt = S_SETUP;
        end
      end
      S_SAMPLE: begin
        cmd.sample = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      act_r       <= ACT_ROCK;
      player_r    <= PLAYER_MY;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      act_r       <= act_nxt;
      player_r    <= player_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second transaction accepted while busy");

  a_commit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_tready))
    else $error("result overwrote an untaken transaction");

  a_valid_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result raised outside commit");

endmodule

>>> rtl/core/rmsp_dp.sv
// ----------------------------------------------------------------------------
// rmsp_dp
// Regret and strategy-sum state, shared restoring divider, sampler, output.
// ----------------------------------------------------------------------------
module rmsp_dp
  import rmsp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IN_W-1:0]  in_tdata,
  input  rmsp_cmd_t        cmd,
  output rmsp_stat_t       stat,
  output logic [OUT_W-1:0] out_tdata
);

  logic signed [REGRET_WIDTH-1:0] regret_r [2][3];
  logic [SUM_WIDTH-1:0]           sum_r [3];
  logic [SUM_WIDTH-1:0]           sum_new [3];
  logic [PROB_W-1:0]              prob_r [2][3];
  logic [RND_W-1:0]               rnd_r [2];
  act_t                           act_r [2];
  act_t                           act_new [2];
  logic [TOT_W-1:0]               total_r, total_nxt, rem_r, rem_step, num;
  logic [TOT_W:0]                 rem2;
  logic [PROB_FRAC_BITS-1:0]      quot_r;
  logic                           byp_r;
  logic [PROB_W-1:0]              byp_val_r;
  logic                           rem_ge;
  logic [OUT_W-1:0]               out_data_nxt;

  function automatic logic [POS_W-1:0] pos_of(input logic signed [REGRET_WIDTH-1:0] v);
    return (!v[REGRET_WIDTH-1] && (|v)) ? v[POS_W-1:0] : '0;
  endfunction

  function automatic logic below(input logic [RND_W-1:0] r, input logic [CUM_W-1:0] cum);
    logic [CMP_W-1:0] lhs;
    logic [CMP_W-1:0] rhs;
    lhs = CMP_W'(r) << PROB_FRAC_BITS;
    rhs = CMP_W'(cum) << 16;
    return lhs < rhs;
  endfunction

  function automatic act_t draw(input logic [RND_W-1:0] r, input logic [PROB_W-1:0] p0,
                                input logic [PROB_W-1:0] p1);
    logic [CUM_W-1:0] c0;
    logic [CUM_W-1:0] c1;
    c0 = CUM_W'(p0);
    c1 = c0 + CUM_W'(p1);
    if (below(r, c0)) return ACT_ROCK;
    if (below(r, c1)) return ACT_PAPER;
    return ACT_SCISSORS;
  endfunction

  function automatic logic signed [REGRET_WIDTH-1:0] sat_regret(
    input logic signed [REGRET_WIDTH-1:0] v, input logic signed [2:0] d);
    logic signed [REGRET_WIDTH:0] ext;
    ext = {v[REGRET_WIDTH-1], v} + {{(REGRET_WIDTH-2){d[2]}}, d};
    if (ext[REGRET_WIDTH] != ext[REGRET_WIDTH-1]) begin
      return ext[REGRET_WIDTH] ? {1'b1, {(REGRET_WIDTH-1){1'b0}}}
                               : {1'b0, {(REGRET_WIDTH-1){1'b1}}};
    end
    return ext[REGRET_WIDTH-1:0];
  endfunction

  function automatic logic signed [2:0] regret_delta(input act_t a, input act_t self,
                                                     input act_t other);
    logic signed [1:0] ua;
    logic signed [1:0] us;
    ua = utility(a, other);
    us = utility(self, other);
    return {ua[1], ua} - {us[1], us};
  endfunction

  // strategy build and divider
  assign total_nxt = TOT_W'(pos_of(regret_r[cmd.player][0]))
                   + TOT_W'(pos_of(regret_r[cmd.player][1]))
                   + TOT_W'(pos_of(regret_r[cmd.player][2]));
  assign num         = TOT_W'(pos_of(regret_r[cmd.player][cmd.act]));
  assign stat.bypass = (total_r == '0) || (num >= total_r);
  assign rem2        = {rem_r, 1'b0};
  assign rem_ge      = rem2 >= {1'b0, total_r};
  assign rem_step    = rem_ge ? TOT_W'(rem2 - {1'b0, total_r}) : rem2[TOT_W-1:0];

  assign act_new[0] = draw(rnd_r[0], prob_r[0][0], prob_r[0][1]);
  assign act_new[1] = draw(rnd_r[1], prob_r[1][0], prob_r[1][1]);

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic [SUM_WIDTH:0] s;
      s = {1'b0, sum_r[a]} + (SUM_WIDTH + 1)'(prob_r[0][a]);
      sum_new[a] = s[SUM_WIDTH] ? {SUM_WIDTH{1'b1}} : s[SUM_WIDTH-1:0];
    end
  end

  assign out_data_nxt = {
    (OUT_W - OUT_FIELDS_W)'(0),
    OUT_SUM_W'(sum_new[2]), OUT_SUM_W'(sum_new[1]), OUT_SUM_W'(sum_new[0]),
    OUT_PROB_W'(prob_r[1][2]), OUT_PROB_W'(prob_r[1][1]), OUT_PROB_W'(prob_r[1][0]),
    OUT_PROB_W'(prob_r[0][2]), OUT_PROB_W'(prob_r[0][1]), OUT_PROB_W'(prob_r[0][0]),
    act_r[1], act_r[0]
  };

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rnd_r[0] <= in_tdata[RND_W-1:0];
      rnd_r[1] <= in_tdata[IN_W-1:RND_W];
    end
    if (cmd.load_total) begin
      total_r <= total_nxt;
    end
    if (cmd.div_start) begin
      rem_r     <= num;
      quot_r    <= '0;
      byp_r     <= stat.bypass;
      byp_val_r <= (total_r == '0) ? PROB_UNIFORM : PROB_ONE;
    end
    if (cmd.div_step) begin
      rem_r  <= rem_step;
      quot_r <= {quot_r[PROB_FRAC_BITS-2:0], rem_ge};
    end
    if (cmd.div_store) begin
      prob_r[cmd.player][cmd.act] <= byp_r ? byp_val_r : PROB_W'(quot_r);
    end
    if (cmd.sample) begin
      act_r[0] <= act_new[0];
      act_r[1] <= act_new[1];
    end
    if (cmd.commit) begin
      out_tdata <= out_data_nxt;
    end
  end

  // learning state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        regret_r[0][a] <= '0;
        regret_r[1][a] <= '0;
        sum_r[a]       <= '0;
      end
    end else if (cmd.commit) begin
      for (int a = 0; a < 3; a++) begin
        regret_r[0][a] <= sat_regret(regret_r[0][a],
                                     regret_delta(act_t'(a), act_r[0], act_r[1]));
        regret_r[1][a] <= sat_regret(regret_r[1][a],
                                     regret_delta(act_t'(a), act_r[1], act_r[0]));
        sum_r[a]       <= sum_new[a];
      end
    end
  end

  a_sum_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> (sum_r[0] >= $past(sum_r[0])) && (sum_r[1] >= $past(sum_r[1]))
                   && (sum_r[2] >= $past(sum_r[2])))
    else $error("strategy sum decreased");

endmodule

>>> rtl/core/regret_matching_self_play_step_top.sv
// ----------------------------------------------------------------------------
// regret_matching_self_play_step_top
// One regret matching self-play iteration of rock-paper-scissors per transaction.
// ----------------------------------------------------------------------------
// One input transaction runs one iteration. The single shared restoring
// divider forms each of the six normalized probabilities in turn, one quotient
// bit per cycle; a probability with no positive regret total, or whose regret
// equals the total, skips the divider. The next transaction is taken as soon
// as the result is registered, even while it still waits for out_tready.
module regret_matching_self_play_step_top
  import rmsp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // my_random, opp_random
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // my_action, opp_action, my_prob_0..2,
                                       // opp_prob_0..2, my_sum_0..2, zero pad
);

  rmsp_cmd_t  cmd;
  rmsp_stat_t stat;

  rmsp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  rmsp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_tdata (out_tdata)
  );

endmodule

>>> tb/sv/tb_regret_matching_self_play_step_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_regret_matching_self_play_step_top
// Self-checking bench for the regret matching self-play step block. Each
// transaction is one rock-paper-scissors iteration; a local model of both
// players' regrets and the first player's strategy sums predicts every
// result. Covers uniform start, sampling fallback, exact cumulative
// boundaries, random play with bursty stalls on both sides, a long output
// hold-off, a drain pause and a final gap-free stream.
// ----------------------------------------------------------------------------
module tb_regret_matching_self_play_step_top;
  import rmsp_pkg::*;

  localparam int           CYCLE_LIMIT = 1000000;
  localparam int           DRAIN_WAIT  = 200;
  localparam int           LONG_HOLD   = 400;
  localparam longint       REG_MAX     = 64'sd2147483647;
  localparam longint       REG_MIN     = -64'sd2147483648;
  localparam logic [63:0]  SUM_MAX     = 64'h0000_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [5:0]        pad;
    logic [47:0]       my_sum_2;
    logic [47:0]       my_sum_1;
    logic [47:0]       my_sum_0;
    logic [16:0]       opp_prob_2;
    logic [16:0]       opp_prob_1;
    logic [16:0]       opp_prob_0;
    logic [16:0]       my_prob_2;
    logic [16:0]       my_prob_1;
    logic [16:0]       my_prob_0;
    act_t              opp_action;
    act_t              my_action;
  } iter_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;   // my_random, opp_random
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;       // my_action, opp_action, my_prob_0..2,
                                     // opp_prob_0..2, my_sum_0..2, zero pad

  regret_matching_self_play_step_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  logic [2:0][31:0] my_regret_q  = '0;
  logic [2:0][31:0] opp_regret_q = '0;
  logic [2:0][47:0] strat_sum_q  = '0;

  iter_result_t expected_results[$];
  bit           idle_en = 1'b1;
  int           hold_left = 0;
  int           stall_left = 0;
  int           iterations_sent = 0;
  int           results_checked = 0;
  int           mismatch_count = 0;
  int           error_count = 0;
  int           cycle_count = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("tb_regret_matching_self_play_step_top: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------- model
  function automatic logic [16:0] frac_quotient(input logic [63:0] num,
                                                input logic [63:0] den);
    logic [63:0] rem;
    logic [16:0] q;
    if (num >= den) return PROB_ONE;
    rem = num;
    q   = '0;
    for (int i = 0; i < PROB_FRAC_BITS; i++) begin
      rem = rem << 1;
      q   = q << 1;
      if (rem >= den) begin
        rem  = rem - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [2:0][16:0] form_strategy(input logic [2:0][31:0] regret);
    logic [2:0][63:0] pos;
    logic [63:0]      total;
    logic [2:0][16:0] prob;
    total = '0;
    for (int a = 0; a < 3; a++) begin
      pos[a] = ($signed(regret[a]) > 0) ? 64'(regret[a]) : 64'd0;
      total  = total + pos[a];
    end
    for (int a = 0; a < 3; a++)
      prob[a] = (total == 0) ? PROB_UNIFORM : frac_quotient(pos[a], total);
    return prob;
  endfunction

  function automatic act_t draw_action(input logic [2:0][16:0] prob,
                                       input logic [15:0] r);
    logic [18:0] cum;
    cum = '0;
    for (int a = 0; a < 3; a++) begin
      cum = cum + prob[a];
      if ({3'b000, r} < cum) return act_t'(a);
    end
    return ACT_SCISSORS;
  endfunction

  function automatic int payoff(input int act, input int other);
    if (act == (other + 1) % 3) return 1;
    if (act == (other + 2) % 3) return -1;
    return 0;
  endfunction

  function automatic logic [31:0] regret_add(input logic [31:0] r, input int delta);
    longint v;
    v = longint'($signed(r)) + delta;
    if (v > REG_MAX) v = REG_MAX;
    else if (v < REG_MIN) v = REG_MIN;
    return 32'(v);
  endfunction

  function automatic iter_result_t predict_iteration(input logic [15:0] my_r,
                                                     input logic [15:0] opp_r);
    logic [2:0][16:0] mp;
    logic [2:0][16:0] op;
    act_t             ma;
    act_t             oa;
    iter_result_t     res;
    mp = form_strategy(my_regret_q);
    op = form_strategy(opp_regret_q);
    for (int a = 0; a < 3; a++)
      strat_sum_q[a] = (64'(strat_sum_q[a]) + 64'(mp[a]) > SUM_MAX) ?
                       SUM_MAX[47:0] : strat_sum_q[a] + 48'(mp[a]);
    ma = draw_action(mp, my_r);
    oa = draw_action(op, opp_r);
    for (int a = 0; a < 3; a++) begin
      my_regret_q[a]  = regret_add(my_regret_q[a],
                                   payoff(a, int'(oa)) - payoff(int'(ma), int'(oa)));
      opp_regret_q[a] = regret_add(opp_regret_q[a],
                                   payoff(a, int'(ma)) - payoff(int'(oa), int'(ma)));
    end
    res            = '0;
    res.my_action  = ma;
    res.opp_action = oa;
    res.my_prob_0  = mp[0];
    res.my_prob_1  = mp[1];
    res.my_prob_2  = mp[2];
    res.opp_prob_0 = op[0];
    res.opp_prob_1 = op[1];
    res.opp_prob_2 = op[2];
    res.my_sum_0   = strat_sum_q[0];
    res.my_sum_1   = strat_sum_q[1];
    res.my_sum_2   = strat_sum_q[2];
    return res;
  endfunction

  // -------------------------------------------------------------- drivers
  task automatic send_iteration(input logic [15:0] my_r, input logic [15:0] opp_r);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {opp_r, my_r};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_results.push_back(predict_iteration(my_r, opp_r));
    iterations_sent++;
  endtask

  function automatic logic [15:0] rand_draw();
    case ($urandom_range(0, 15))
      0:       return 16'($urandom_range(0, 3));
      1:       return 16'(65535 - $urandom_range(0, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] near_boundary(input logic [18:0] c, input bit below);
    logic [18:0] v;
    v = (below && c != 0) ? c - 19'd1 : c;
    return (v > 19'd65535) ? 16'hFFFF : v[15:0];
  endfunction

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // -------------------------------------------------------------- checker
  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      mismatch_count++;
      error_count++;
      if (mismatch_count <= 10)
        $display("result %0d %s: expected %0d, got %0d",
                 results_checked, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    iter_result_t got;
    iter_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = iter_result_t'(out_tdata);
      if (expected_results.size() == 0) begin
        error_count++;
        $display("unexpected result transaction at cycle %0d", cycle_count);
      end else begin
        want = expected_results.pop_front();
        check_field("my_action",  64'(want.my_action),  64'(got.my_action));
        check_field("opp_action", 64'(want.opp_action), 64'(got.opp_action));
        check_field("my_prob_0",  64'(want.my_prob_0),  64'(got.my_prob_0));
        check_field("my_prob_1",  64'(want.my_prob_1),  64'(got.my_prob_1));
        check_field("my_prob_2",  64'(want.my_prob_2),  64'(got.my_prob_2));
        check_field("opp_prob_0", 64'(want.opp_prob_0), 64'(got.opp_prob_0));
        check_field("opp_prob_1", 64'(want.opp_prob_1), 64'(got.opp_prob_1));
        check_field("opp_prob_2", 64'(want.opp_prob_2), 64'(got.opp_prob_2));
        check_field("my_sum_0",   64'(want.my_sum_0),   64'(got.my_sum_0));
        check_field("my_sum_1",   64'(want.my_sum_1),   64'(got.my_sum_1));
        check_field("my_sum_2",   64'(want.my_sum_2),   64'(got.my_sum_2));
        check_field("pad",        64'(want.pad),        64'(got.pad));
        results_checked++;
      end
    end
  end

  // ---------------------------------------------------------------- tests
  // uniform strategy from reset; 65535 against 21845*3 takes the fallback
  task automatic test_uniform_after_reset();
    send_iteration(16'hFFFF, 16'hFFFF);
    send_iteration(16'h0000, 16'h0000);
  endtask

  task automatic test_field_extremes();
    send_iteration(16'hFFFF, 16'h0000);
    send_iteration(16'h0000, 16'hFFFF);
    send_iteration(16'hAAAA, 16'h5555);
    send_iteration(16'h5555, 16'hAAAA);
    send_iteration(16'd21844, 16'd21845);
    send_iteration(16'd43690, 16'd43689);
    send_iteration(16'h8000, 16'h7FFF);
    send_iteration(16'h0001, 16'hFFFE);
  endtask

  // draws placed exactly on and just under the cumulative thresholds
  task automatic test_cumulative_boundaries();
    logic [2:0][16:0] mp;
    logic [2:0][16:0] op;
    logic [18:0]      mc;
    logic [18:0]      oc;
    for (int k = 0; k < 12; k++) begin
      mp = form_strategy(my_regret_q);
      op = form_strategy(opp_regret_q);
      mc = (k % 4 < 2) ? 19'(mp[0]) : 19'(mp[0]) + 19'(mp[1]);
      oc = (k % 4 < 2) ? 19'(op[0]) + 19'(op[1]) : 19'(op[0]);
      send_iteration(near_boundary(mc, k % 2 == 1), near_boundary(oc, k % 2 == 0));
    end
  endtask

  task automatic test_random_play(input int count);
    repeat (count) send_iteration(rand_draw(), rand_draw());
  endtask

  task automatic test_output_backpressure();
    in_tvalid <= 1'b0;
    @(negedge clk);
    hold_left = LONG_HOLD;
    @(posedge clk);
    repeat (12) send_iteration(rand_draw(), rand_draw());
  endtask

  task automatic test_drain_pause();
    repeat (20) send_iteration(rand_draw(), rand_draw());
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) send_iteration(rand_draw(), rand_draw());
  endtask

  task automatic test_steady_stream(input int count);
    idle_en = 1'b0;
    repeat (count) send_iteration(rand_draw(), rand_draw());
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_uniform_after_reset();
    test_field_extremes();
    test_cumulative_boundaries();
    test_random_play(1200);
    test_output_backpressure();
    test_drain_pause();
    test_steady_stream(480);
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("covered %0d iterations and %0d checked results, %0d field mismatches",
             iterations_sent, results_checked, mismatch_count);
    $display("incl. reset uniform, fallback, exact thresholds, long hold-off, drain pause");
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("tb_regret_matching_self_play_step_top: clean");
    end else begin
      $display("tb_regret_matching_self_play_step_top: errors");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/rmsp_pkg.sv
rtl/core/rmsp_ctrl.sv
rtl/core/rmsp_dp.sv
rtl/core/regret_matching_self_play_step_top.sv
tb/sv/tb_regret_matching_self_play_step_top.sv
